// File: src/b64c_pkg.sv
package b64c_pkg;

  // Pad character '=' and the symbol value a released pad stands for
  localparam logic [7:0] PAD_CHAR  = 8'h3D;
  localparam logic [7:0] PAD_VALUE = 8'd61;

  // Most result bytes one input item can give
  localparam int unsigned MAX_RESULTS = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       no_data;
    logic       last_of_message;
  } out_item_t;

  // One queued group of results from a single input item
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [1:0]                  cnt_m1;  // number of bytes minus one
    logic                        last;
    logic                        nodata;
  } grp_entry_t;

  // Six-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      enc_char = 8'h41 + w;
    else if (v < 6'd52) enc_char = 8'h61 + w - 8'd26;
    else if (v < 6'd62) enc_char = 8'h30 + w - 8'd52;
    else if (v == 6'd62) enc_char = 8'h2B;
    else                 enc_char = 8'h2F;
  endfunction

  // Character to symbol value; characters outside the alphabet keep their code
  function automatic logic [7:0] sym_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A)      sym_value = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) sym_value = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39) sym_value = c - 8'h30 + 8'd52;
    else if (c == 8'h2B)               sym_value = 8'd62;
    else if (c == 8'h2F)               sym_value = 8'd63;
    else                               sym_value = c;
  endfunction

  // Byte formed from the previous symbol and the new one, modulo 256
  function automatic logic [7:0] dec_byte(input logic [1:0] cnt,
                                          input logic [7:0] prev,
                                          input logic [7:0] v);
    unique case (cnt)
      2'd1:    dec_byte = {prev[5:0], 2'b00} + {6'b0, v[5:4]};
      2'd2:    dec_byte = {prev[3:0], 4'b0000} + {2'b00, v[7:2]};
      2'd3:    dec_byte = {prev[1:0], 6'b0} + v;
      default: dec_byte = 8'h00;
    endcase
  endfunction

endpackage

// File: src/base64_stream_codec.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_data_i  (b64c_pkg::in_item_t)
// out      output     out_valid_o / out_ready_i out_data_o (b64c_pkg::out_item_t)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (decode_mode)
//
// An input item is taken on a valid and ready handshake. If it yields a byte or
// ends the message, its result bytes (up to four) are queued as one entry; the
// first leaves via the queue and then the output register. The output side sends
// one byte per cycle while out_ready_i is high. Encoding is held by the output
// side, decoding by the input side to one character per cycle; in_ready_o drops
// while the two-entry queue is full. Reset clears mode, group state, queue and
// output; a configuration write clears the group state.
module base64_stream_codec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b64c_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b64c_pkg::out_item_t out_data_o
);

  b64c_pkg::grp_entry_t push_entry, pop_entry;
  logic push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  b64c_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_entry_o   (push_entry)
  );

  b64c_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_entry)
  );

  b64c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_entry_i   (pop_entry),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: src/b64c_front.sv
module b64c_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  input  b64c_pkg::in_item_t   in_data_i,
  output logic                 in_ready_o,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output b64c_pkg::grp_entry_t q_entry_o
);

  logic       mode_q;
  logic [7:0] prev_q, prev_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] held_q, held_d;

  logic [b64c_pkg::MAX_RESULTS-1:0][7:0] bytes_c;
  logic [2:0] n_c;
  logic [7:0] p_c, b_c, sv_c;
  logic [1:0] k_c, np_c;
  logic       take_sym_c, last_c, acc_c;

  assign b_c    = in_data_i.data_byte;
  assign last_c = in_data_i.end_of_message;
  assign sv_c   = b64c_pkg::sym_value(b_c);

  assign in_ready_o = !q_full_i;
  assign acc_c      = in_valid_i && in_ready_o;

  // Work out every result byte of the item and the next group state
  always_comb begin
    bytes_c    = '0;
    n_c        = 3'd0;
    p_c        = prev_q;
    k_c        = cnt_q;
    held_d     = held_q;
    np_c       = 2'd0;
    take_sym_c = 1'b0;
    if (mode_q) begin
      // Decode: up to two pads held back, freed as symbols by text or a pad
      if (b_c == b64c_pkg::PAD_CHAR) begin
        if (held_q == 2'd2) np_c = 2'd1;
        else                held_d = held_q + 2'd1;
      end else begin
        np_c       = held_q;
        take_sym_c = 1'b1;
        held_d     = 2'd0;
      end
      for (int j = 0; j < 3; j++) begin
        if (j < int'(np_c)) begin
          if (k_c != 2'd0) begin
            bytes_c[n_c[1:0]] = b64c_pkg::dec_byte(k_c, p_c, b64c_pkg::PAD_VALUE);
            n_c = n_c + 3'd1;
          end
          p_c = b64c_pkg::PAD_VALUE;
          k_c = k_c + 2'd1;
        end else if (j == int'(np_c) && take_sym_c) begin
          if (k_c != 2'd0) begin
            bytes_c[n_c[1:0]] = b64c_pkg::dec_byte(k_c, p_c, sv_c);
            n_c = n_c + 3'd1;
          end
          p_c = sv_c;
          k_c = k_c + 2'd1;
        end
      end
    end else begin
      // Encode: emit each character once its six bits are known
      unique case (k_c)
        2'd0: begin
          bytes_c[0] = b64c_pkg::enc_char(b_c[7:2]);
          n_c = 3'd1;
          k_c = 2'd1;
        end
        2'd1: begin
          bytes_c[0] = b64c_pkg::enc_char({p_c[1:0], b_c[7:4]});
          n_c = 3'd1;
          k_c = 2'd2;
        end
        default: begin
          bytes_c[0] = b64c_pkg::enc_char({p_c[3:0], b_c[7:6]});
          bytes_c[1] = b64c_pkg::enc_char(b_c[5:0]);
          n_c = 3'd2;
          k_c = 2'd0;
        end
      endcase
      p_c = b_c;
      // Short final group: last character and padding
      if (last_c) begin
        if (k_c == 2'd1) begin
          bytes_c[1] = b64c_pkg::enc_char({b_c[1:0], 4'b0000});
          bytes_c[2] = b64c_pkg::PAD_CHAR;
          bytes_c[3] = b64c_pkg::PAD_CHAR;
          n_c = 3'd4;
        end else if (k_c == 2'd2) begin
          bytes_c[1] = b64c_pkg::enc_char({b_c[3:0], 2'b00});
          bytes_c[2] = b64c_pkg::PAD_CHAR;
          n_c = 3'd3;
        end
      end
    end
    prev_d = p_c;
    cnt_d  = k_c;
    // End of message drops held pads and clears the group
    if (last_c) begin
      prev_d = 8'h00;
      cnt_d  = 2'd0;
      held_d = 2'd0;
    end
  end

  // Queue entry; a final item with nothing to show gives one empty result
  always_comb begin
    q_entry_o.bytes  = bytes_c;
    q_entry_o.cnt_m1 = (n_c == 3'd0) ? 2'd0 : 2'(n_c - 3'd1);
    q_entry_o.last   = last_c;
    q_entry_o.nodata = last_c && (n_c == 3'd0);
  end

  assign q_push_o = acc_c && ((n_c != 3'd0) || last_c);

  // Mode and group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      prev_q <= '0;
      cnt_q  <= '0;
      held_q <= '0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
      prev_q <= '0;
      cnt_q  <= '0;
      held_q <= '0;
    end else if (acc_c) begin
      prev_q <= prev_d;
      cnt_q  <= cnt_d;
      held_q <= held_d;
    end
  end

endmodule

// File: src/b64c_fifo.sv
module b64c_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b64c_pkg::grp_entry_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output b64c_pkg::grp_entry_t pop_data_o
);

  b64c_pkg::grp_entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i)      count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

endmodule

// File: src/b64c_back.sv
module b64c_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  b64c_pkg::grp_entry_t q_entry_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b64c_pkg::out_item_t  out_data_o
);

  b64c_pkg::grp_entry_t cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  logic       done_c, at_end_c;

  assign at_end_c = (idx_q == cur_q.cnt_m1);
  assign done_c   = cur_valid_q && out_ready_i && at_end_c;
  assign q_pop_o  = !q_empty_i && (!cur_valid_q || done_c);

  assign out_valid_o                = cur_valid_q;
  assign out_data_o.out_byte        = cur_q.bytes[idx_q];
  assign out_data_o.no_data         = cur_q.nodata;
  assign out_data_o.last_of_message = cur_q.last && at_end_c;

  // Current entry payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_entry_i;
  end

  // Byte index within the entry and holding flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (q_pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= 2'd0;
    end else if (done_c) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (cur_valid_q && out_ready_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule
